[hdl/segment_pair_relation_unit_defines.svh]
// assertion macros for the segment pair relation unit
// expects clk and rst_n in the scope where a macro is used
`ifndef SEGMENT_PAIR_RELATION_UNIT_DEFINES_SVH
`define SEGMENT_PAIR_RELATION_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SPRU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SPRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/spru_pkg.sv]
// shared types, widths, codes and helper functions of the segment pair relation unit
// no dependencies
package spru_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int TOL_W      = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TOL   = 1'd1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic [TOL_W-1:0]             tol_t;

  typedef enum logic [1:0] {
    REL_NONE      = 2'd0,
    REL_INTERSECT = 2'd1,
    REL_CONNECTED = 2'd2,
    REL_EQUAL     = 2'd3
  } rel_t;

  // stage 1: edge vectors and endpoint differences (p minus q)
  typedef struct packed {
    diff_t dpx, dpy, dqx, dqy;
    diff_t dx11, dx12, dx21, dx22;
    diff_t dy11, dy12, dy21, dy22;
  } diffs_t;

  // stage 2: partial products plus the endpoint match flags
  typedef struct packed {
    prod_t py_x11, px_y11, py_x12, px_y12;
    prod_t qx_y11, qy_x11, qx_y21, qy_x21;
    prod_t x11_12, y11_12, x21_22, y21_22;
    prod_t x11_21, y11_21, x12_22, y12_22;
    logic  x_match, y_match;
  } prods_t;

  // stage 3: cross products c1..c4 and dot products per tested endpoint
  typedef struct packed {
    sum_t c1, c2, c3, c4;
    sum_t dot_p1, dot_p2, dot_q1, dot_q2;
    logic x_match, y_match;
  } sums_t;

  function automatic diff_t sub_coord(coord_t a, coord_t b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  function automatic prod_t mul_diff(diff_t a, diff_t b);
    prod_t ae;
    prod_t be;
    ae = PROD_W'(a);
    be = PROD_W'(b);
    return ae * be;
  endfunction

  function automatic sum_t add_prod(prod_t a, prod_t b);
    return SUM_W'(a) + SUM_W'(b);
  endfunction

  function automatic sum_t sub_prod(prod_t a, prod_t b);
    return SUM_W'(a) - SUM_W'(b);
  endfunction

  // magnitude at or below the bound counts as zero
  function automatic logic is_small(sum_t v, tol_t tol);
    logic [SUM_W-1:0] mag;
    mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    return mag <= SUM_W'(tol);
  endfunction

endpackage

[hdl/spru_if.sv]
// valid/ready channel interfaces for segment pairs and relation results
// depends on spru_pkg
interface spru_in_if;
  import spru_pkg::*;

  logic   valid;
  logic   ready;
  coord_t first_ax, first_ay, first_bx, first_by;
  coord_t second_ax, second_ay, second_bx, second_by;

  modport source (
    output valid, first_ax, first_ay, first_bx, first_by,
    output second_ax, second_ay, second_bx, second_by,
    input  ready
  );
  modport sink (
    input  valid, first_ax, first_ay, first_bx, first_by,
    input  second_ax, second_ay, second_bx, second_by,
    output ready
  );
endinterface

interface spru_out_if;
  import spru_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] relation;

  modport source (output valid, relation, input ready);
  modport sink (input valid, relation, output ready);
endinterface

[hdl/segment_pair_relation_unit.sv]
// top level of the segment pair relation unit: config registers and four-stage pipeline
// depends on spru_pkg, spru_if, spru_diff, spru_mult, spru_sum, spru_classify
// and segment_pair_relation_unit_defines.svh
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+----------------------------------------------
//  in_seg   | in  | valid / ready  | first_ax..first_by, second_ax..second_by
//  out_rel  | out | valid / ready  | relation (0 none, 1 intersect, 2 connected, 3 equal)
//  cfg_*    | in  | cfg_we only    | cfg_index (0 tolerance, 1 default), cfg_wdata
//
// one segment pair per cycle sustained while out_rel.ready stays high
// a pair passes through the stages in order: differences, multipliers, sums, sign tests
// each stage holds its own valid bit and accepts when empty or when its successor moves,
// so bubbles close up and a stall at the output backs up without loss or repeats
// reset (synchronous, active low) empties all stages and clears both tolerances to zero
`include "segment_pair_relation_unit_defines.svh"

module segment_pair_relation_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  spru_in_if.sink                          in_seg,
  spru_out_if.source                       out_rel,
  input  logic                             cfg_we,
  input  logic [spru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spru_pkg::TOL_W-1:0]       cfg_wdata
);
  import spru_pkg::*;

  // tolerance registers; the user must write them only while the pipeline is idle, the block does not enforce it
  tol_t tol_r;
  tol_t def_tol_r;

  // stage to stage links
  logic   s1_valid, s1_ready;
  diffs_t s1_data;
  logic   s2_valid, s2_ready;
  prods_t s2_data;
  logic   s3_valid, s3_ready;
  sums_t  s3_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r     <= '0;
      def_tol_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOLERANCE:   tol_r     <= cfg_wdata;
        CFG_DEFAULT_TOL: def_tol_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1: coordinate differences
  spru_diff u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_seg   (in_seg),
    .dn_ready (s1_ready),
    .dn_valid (s1_valid),
    .dn_data  (s1_data)
  );

  // stage 2: products and endpoint match flags (explicit tolerance)
  spru_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .tolerance (tol_r),
    .up_valid  (s1_valid),
    .up_ready  (s1_ready),
    .up_data   (s1_data),
    .dn_ready  (s2_ready),
    .dn_valid  (s2_valid),
    .dn_data   (s2_data)
  );

  // stage 3: cross and dot products
  spru_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_ready (s3_ready),
    .dn_valid (s3_valid),
    .dn_data  (s3_data)
  );

  // stage 4: sign tests, decision and result register
  spru_classify u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .tolerance   (tol_r),
    .default_tol (def_tol_r),
    .up_valid    (s3_valid),
    .up_ready    (s3_ready),
    .up_data     (s3_data),
    .out_rel     (out_rel)
  );

  // input backpressure only when every stage holds a transaction
  `SPRU_ASSERT_NOW(a_full_when_blocked, !in_seg.ready,
                   s1_valid && s2_valid && s3_valid && out_rel.valid,
                   "input blocked with an empty stage")
  // a stalled stage 1 transaction is kept
  `SPRU_ASSERT_NEXT(a_s1_held, s1_valid && !s1_ready, s1_valid,
                    "stage 1 transaction dropped under stall")
  // a new result comes only from a filled stage 3
  `SPRU_ASSERT_NOW(a_out_from_s3, $rose(out_rel.valid), $past(s3_valid),
                   "result appeared without a stage 3 transaction")
endmodule

[hdl/spru_diff.sv]
// stage 1: takes a segment pair transaction and registers all coordinate differences
// depends on spru_pkg and spru_in_if
module spru_diff (
  input  logic           clk,
  input  logic           rst_n,
  spru_in_if.sink        in_seg,
  input  logic           dn_ready,
  output logic           dn_valid,
  output spru_pkg::diffs_t dn_data
);
  import spru_pkg::*;

  logic   v_r;
  diffs_t data_r;
  diffs_t data_nxt;

  assign in_seg.ready = !v_r || dn_ready;
  assign dn_valid     = v_r;
  assign dn_data      = data_r;

  always_comb begin
    data_nxt.dpx  = sub_coord(in_seg.first_bx, in_seg.first_ax);
    data_nxt.dpy  = sub_coord(in_seg.first_by, in_seg.first_ay);
    data_nxt.dqx  = sub_coord(in_seg.second_bx, in_seg.second_ax);
    data_nxt.dqy  = sub_coord(in_seg.second_by, in_seg.second_ay);
    data_nxt.dx11 = sub_coord(in_seg.first_ax, in_seg.second_ax);
    data_nxt.dx12 = sub_coord(in_seg.first_ax, in_seg.second_bx);
    data_nxt.dx21 = sub_coord(in_seg.first_bx, in_seg.second_ax);
    data_nxt.dx22 = sub_coord(in_seg.first_bx, in_seg.second_bx);
    data_nxt.dy11 = sub_coord(in_seg.first_ay, in_seg.second_ay);
    data_nxt.dy12 = sub_coord(in_seg.first_ay, in_seg.second_by);
    data_nxt.dy21 = sub_coord(in_seg.first_by, in_seg.second_ay);
    data_nxt.dy22 = sub_coord(in_seg.first_by, in_seg.second_by);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_seg.ready) begin
      v_r <= in_seg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_seg.ready && in_seg.valid) begin
      data_r <= data_nxt;
    end
  end
endmodule

[hdl/spru_mult.sv]
// stage 2: sixteen parallel 17x17 multipliers and the endpoint coordinate match flags
// depends on spru_pkg
module spru_mult (
  input  logic             clk,
  input  logic             rst_n,
  input  spru_pkg::tol_t   tolerance,
  input  logic             up_valid,
  output logic             up_ready,
  input  spru_pkg::diffs_t up_data,
  input  logic             dn_ready,
  output logic             dn_valid,
  output spru_pkg::prods_t dn_data
);
  import spru_pkg::*;

  logic   v_r;
  prods_t data_r;
  prods_t data_nxt;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  always_comb begin
    // cross product terms
    data_nxt.py_x11 = mul_diff(up_data.dpy, up_data.dx11);
    data_nxt.px_y11 = mul_diff(up_data.dpx, up_data.dy11);
    data_nxt.py_x12 = mul_diff(up_data.dpy, up_data.dx12);
    data_nxt.px_y12 = mul_diff(up_data.dpx, up_data.dy12);
    data_nxt.qx_y11 = mul_diff(up_data.dqx, up_data.dy11);
    data_nxt.qy_x11 = mul_diff(up_data.dqy, up_data.dx11);
    data_nxt.qx_y21 = mul_diff(up_data.dqx, up_data.dy21);
    data_nxt.qy_x21 = mul_diff(up_data.dqy, up_data.dx21);
    // dot product terms
    data_nxt.x11_12 = mul_diff(up_data.dx11, up_data.dx12);
    data_nxt.y11_12 = mul_diff(up_data.dy11, up_data.dy12);
    data_nxt.x21_22 = mul_diff(up_data.dx21, up_data.dx22);
    data_nxt.y21_22 = mul_diff(up_data.dy21, up_data.dy22);
    data_nxt.x11_21 = mul_diff(up_data.dx11, up_data.dx21);
    data_nxt.y11_21 = mul_diff(up_data.dy11, up_data.dy21);
    data_nxt.x12_22 = mul_diff(up_data.dx12, up_data.dx22);
    data_nxt.y12_22 = mul_diff(up_data.dy12, up_data.dy22);
    data_nxt.x_match = is_small(SUM_W'(up_data.dx11), tolerance) ||
                       is_small(SUM_W'(up_data.dx12), tolerance) ||
                       is_small(SUM_W'(up_data.dx21), tolerance) ||
                       is_small(SUM_W'(up_data.dx22), tolerance);
    data_nxt.y_match = is_small(SUM_W'(up_data.dy11), tolerance) ||
                       is_small(SUM_W'(up_data.dy12), tolerance) ||
                       is_small(SUM_W'(up_data.dy21), tolerance) ||
                       is_small(SUM_W'(up_data.dy22), tolerance);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end
endmodule

[hdl/spru_sum.sv]
// stage 3: combines partial products into four cross products and four dot products
// depends on spru_pkg
module spru_sum (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  spru_pkg::prods_t up_data,
  input  logic             dn_ready,
  output logic             dn_valid,
  output spru_pkg::sums_t  dn_data
);
  import spru_pkg::*;

  logic  v_r;
  sums_t data_r;
  sums_t data_nxt;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt.c1      = sub_prod(up_data.py_x11, up_data.px_y11);
    data_nxt.c2      = sub_prod(up_data.py_x12, up_data.px_y12);
    data_nxt.c3      = sub_prod(up_data.qx_y11, up_data.qy_x11);
    data_nxt.c4      = sub_prod(up_data.qx_y21, up_data.qy_x21);
    data_nxt.dot_p1  = add_prod(up_data.x11_12, up_data.y11_12);
    data_nxt.dot_p2  = add_prod(up_data.x21_22, up_data.y21_22);
    data_nxt.dot_q1  = add_prod(up_data.x11_21, up_data.y11_21);
    data_nxt.dot_q2  = add_prod(up_data.x12_22, up_data.y12_22);
    data_nxt.x_match = up_data.x_match;
    data_nxt.y_match = up_data.y_match;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end
endmodule

[hdl/spru_classify.sv]
// stage 4: tolerance sign tests and relation decision, drives the result register
// depends on spru_pkg and spru_out_if
module spru_classify (
  input  logic            clk,
  input  logic            rst_n,
  input  spru_pkg::tol_t  tolerance,
  input  spru_pkg::tol_t  default_tol,
  input  logic            up_valid,
  output logic            up_ready,
  input  spru_pkg::sums_t up_data,
  spru_out_if.source      out_rel
);
  import spru_pkg::*;

  logic v_r;
  rel_t rel_r;
  rel_t rel_nxt;
  logic z1, z2, z3, z4;
  logic n1, n2, n3, n4;
  logic straddle;
  logic on_p1, on_p2, on_q1, on_q2;
  logic line_off;

  assign up_ready         = !v_r || out_rel.ready;
  assign out_rel.valid    = v_r;
  assign out_rel.relation = rel_r;

  always_comb begin
    z1 = is_small(up_data.c1, default_tol);
    z2 = is_small(up_data.c2, default_tol);
    z3 = is_small(up_data.c3, default_tol);
    z4 = is_small(up_data.c4, default_tol);
    n1 = up_data.c1[SUM_W-1];
    n2 = up_data.c2[SUM_W-1];
    n3 = up_data.c3[SUM_W-1];
    n4 = up_data.c4[SUM_W-1];
    // strictly opposite nonzero signs on both segments
    straddle = !z1 && !z2 && (n1 != n2) && !z3 && !z4 && (n3 != n4);
    // on the other segment: zero cross and a dot product that is not positive
    on_p1 = z3 && (up_data.dot_p1[SUM_W-1] || is_small(up_data.dot_p1, default_tol));
    on_p2 = z4 && (up_data.dot_p2[SUM_W-1] || is_small(up_data.dot_p2, default_tol));
    on_q1 = z1 && (up_data.dot_q1[SUM_W-1] || is_small(up_data.dot_q1, default_tol));
    on_q2 = z2 && (up_data.dot_q2[SUM_W-1] || is_small(up_data.dot_q2, default_tol));
    line_off = !is_small(up_data.c1, tolerance) || !is_small(up_data.c2, tolerance);

    priority if (up_data.x_match && up_data.y_match) begin
      rel_nxt = line_off ? REL_CONNECTED : REL_EQUAL;
    end else if (straddle || on_p1 || on_p2 || on_q1 || on_q2) begin
      rel_nxt = REL_INTERSECT;
    end else begin
      rel_nxt = REL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rel_r <= rel_nxt;
    end
  end
endmodule

[dv/spru_relation_checker.sv]
`timescale 1ns / 1ps
// relation checker: watches the segment pair and relation channels, predicts and compares
// depends on spru_pkg and the spru_in_if / spru_out_if interfaces
module spru_relation_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  spru_in_if                             in_seg,
  spru_out_if                            out_rel,
  input  logic                           cfg_we,
  input  logic [spru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  spru_pkg::tol_t                 cfg_wdata,
  output int                             mismatches,
  output int                             outstanding,
  output int                             checked,
  output logic [3:0][15:0]               rel_tally
);
  import spru_pkg::*;

  // shadow copies of the two zero bounds
  tol_t near_tol;
  tol_t line_tol;
  rel_t pending_rel_q[$];

  // twice the signed area of triangle (a, b, p)
  function automatic longint area2(longint ax, longint ay, longint bx, longint by,
                                   longint px, longint py);
    return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
  endfunction

  function automatic bit near_zero(longint v, tol_t tol);
    longint mag;
    mag = (v < 0) ? -v : v;
    return mag <= longint'(tol);
  endfunction

  function automatic int tol_dir(longint v, tol_t tol);
    if (near_zero(v, tol)) return 0;
    return (v < 0) ? -1 : 1;
  endfunction

  // point p on segment a-b: zero area and the point between the ends
  function automatic bit lies_on(longint px, longint py, longint ax, longint ay,
                                 longint bx, longint by, tol_t tol);
    longint dot;
    if (!near_zero(area2(ax, ay, bx, by, px, py), tol)) return 1'b0;
    dot = (px - ax) * (px - bx) + (py - ay) * (py - by);
    return tol_dir(dot, tol) <= 0;
  endfunction

  function automatic rel_t classify_pair(longint p1x, longint p1y, longint p2x, longint p2y,
                                         longint q1x, longint q1y, longint q2x, longint q2y,
                                         tol_t t, tol_t d);
    bit x_hit;
    bit y_hit;
    int s1, s2, s3, s4;
    x_hit = near_zero(p1x - q1x, t) || near_zero(p1x - q2x, t) ||
            near_zero(p2x - q1x, t) || near_zero(p2x - q2x, t);
    y_hit = near_zero(p1y - q1y, t) || near_zero(p1y - q2y, t) ||
            near_zero(p2y - q1y, t) || near_zero(p2y - q2y, t);
    if (x_hit && y_hit) begin
      if (!near_zero(area2(p1x, p1y, p2x, p2y, q1x, q1y), t) ||
          !near_zero(area2(p1x, p1y, p2x, p2y, q2x, q2y), t))
        return REL_CONNECTED;
      return REL_EQUAL;
    end
    s1 = tol_dir(area2(p1x, p1y, p2x, p2y, q1x, q1y), d);
    s2 = tol_dir(area2(p1x, p1y, p2x, p2y, q2x, q2y), d);
    s3 = tol_dir(area2(q1x, q1y, q2x, q2y, p1x, p1y), d);
    s4 = tol_dir(area2(q1x, q1y, q2x, q2y, p2x, p2y), d);
    if (s1 != 0 && s1 == -s2 && s3 != 0 && s3 == -s4) return REL_INTERSECT;
    if (lies_on(p1x, p1y, q1x, q1y, q2x, q2y, d) || lies_on(p2x, p2y, q1x, q1y, q2x, q2y, d) ||
        lies_on(q1x, q1y, p1x, p1y, p2x, p2y, d) || lies_on(q2x, q2y, p1x, p1y, p2x, p2y, d))
      return REL_INTERSECT;
    return REL_NONE;
  endfunction

  always @(posedge clk) begin : watch_channels
    rel_t want;
    if (!rst_n) begin
      near_tol = '0;
      line_tol = '0;
      rel_tally = '0;
      pending_rel_q.delete();
    end else begin
      if (in_seg.valid && in_seg.ready) begin
        want = classify_pair(in_seg.first_ax, in_seg.first_ay, in_seg.first_bx, in_seg.first_by,
                             in_seg.second_ax, in_seg.second_ay,
                             in_seg.second_bx, in_seg.second_by, near_tol, line_tol);
        pending_rel_q.push_back(want);
      end
      if (out_rel.valid && out_rel.ready) begin
        if (pending_rel_q.size() == 0) begin
          $display("%0t: relation transaction with nothing pending: expected none, actual %0d",
                   $time, out_rel.relation);
          mismatches++;
        end else begin
          want = pending_rel_q.pop_front();
          checked++;
          rel_tally[want] = rel_tally[want] + 16'd1;
          if (out_rel.relation !== want) begin
            $display("%0t: relation mismatch: expected %0d (%s), actual %0d",
                     $time, want, want.name(), out_rel.relation);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOLERANCE:   near_tol = cfg_wdata;
          CFG_DEFAULT_TOL: line_tol = cfg_wdata;
          default: ;
        endcase
      end
    end
    outstanding <= pending_rel_q.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// top of the segment pair relation testbench: clock, reset, stimulus and verdict
// depends on spru_pkg, spru_if, segment_pair_relation_unit and spru_relation_checker
module tb;
  import spru_pkg::*;

  // no transaction on either side for this long means the block is stuck
  localparam int STALL_LIMIT  = 2000;
  // pipeline depth plus margin, waited out before a register write and at the end
  localparam int DRAIN_CYCLES = 8;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  tol_t                 cfg_wdata;

  spru_in_if  in_seg ();
  spru_out_if out_rel ();

  int               mismatches;
  int               outstanding;
  int               checked;
  logic [3:0][15:0] rel_tally;

  // when set, neither side idles
  bit no_idle;
  int idle_cycles;
  int sent_pairs;
  int settings_run;

  // coordinates of the next pair: first a, first b, second a, second b (x then y)
  int seg_pt [8];

  segment_pair_relation_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_seg    (in_seg),
    .out_rel   (out_rel),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  spru_relation_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_seg      (in_seg),
    .out_rel     (out_rel),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .rel_tally   (rel_tally)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side back-pressure: ready drops in about ten percent of cycles unless no_idle is set
  initial out_rel.ready = 1'b0;
  always @(posedge clk) begin
    out_rel.ready <= no_idle || ($urandom_range(99) >= 10);
  end

  // watchdog: counts cycles in which no transaction moves on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_seg.valid && in_seg.ready) || (out_rel.valid && out_rel.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("tb failed");
        $finish;
      end
    end
  end

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // keep constructed points inside the 16-bit coordinate range
  function automatic coord_t to_coord(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return coord_t'(v);
  endfunction

  function automatic int edge_value();
    case ($urandom_range(7))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 21845;
      6: return 32766;
      default: return 32767;
    endcase
  endfunction

  task automatic set_pair(int a, int b, int c, int d, int e, int f, int g, int h);
    seg_pt = '{a, b, c, d, e, f, g, h};
  endtask

  // one pair per transaction; random gaps of valid low before it
  task automatic send_pair();
    while (!no_idle && $urandom_range(99) < 10) begin
      in_seg.valid <= 1'b0;
      @(posedge clk);
    end
    in_seg.valid     <= 1'b1;
    in_seg.first_ax  <= to_coord(seg_pt[0]);
    in_seg.first_ay  <= to_coord(seg_pt[1]);
    in_seg.first_bx  <= to_coord(seg_pt[2]);
    in_seg.first_by  <= to_coord(seg_pt[3]);
    in_seg.second_ax <= to_coord(seg_pt[4]);
    in_seg.second_ay <= to_coord(seg_pt[5]);
    in_seg.second_bx <= to_coord(seg_pt[6]);
    in_seg.second_by <= to_coord(seg_pt[7]);
    @(posedge clk);
    while (!in_seg.ready) @(posedge clk);
    sent_pairs++;
  endtask

  // lower valid, wait for every pending relation, then let the pipeline go quiet
  task automatic drain_pipe();
    in_seg.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write enable stays high afterwards; the caller lowers it once all writes are done
  task automatic write_tol(logic [CFG_IDX_W-1:0] idx, tol_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // hand-picked pairs, run with both bounds at their reset value of zero
  task automatic directed_pair(int k);
    case (k)
      0:  set_pair(0, 0, 0, 0, 0, 0, 0, 0);                       // two equal point segments
      1:  set_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
      2:  set_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
      3:  set_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      4:  set_pair(0, 0, 10, 10, 1, 9, 9, 2);                     // proper crossing
      5:  set_pair(0, 0, 10, 0, 5, 0, 7, 6);                      // T on the interior
      6:  set_pair(0, 0, 10, 10, 5, 5, 15, 15);                   // collinear, overlapping
      7:  set_pair(0, 0, 3, 3, 5, 5, 9, 9);                       // collinear, apart
      8:  set_pair(0, 0, 10, 0, 1, 5, 11, 5);                     // parallel
      9:  set_pair(0, 0, 10, 0, 10, 0, 12, 7);                    // shared endpoint
      10: set_pair(3, 4, 100, -7, 3, 4, 100, -7);                 // identical
      11: set_pair(3, 4, 100, -7, 100, -7, 3, 4);                 // identical, reversed
      12: set_pair(0, 0, 10, 10, 4, 4, 4, 4);                     // point on a segment
      13: set_pair(0, 0, 10, 10, 4, 5, 4, 5);                     // point just off it
      14: set_pair(1, 2, 1, 2, 3, 5, 3, 5);                       // two distinct points
      15: set_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
      16: set_pair(-32768, -32767, 32767, 32766, -32767, 32767, 32766, -32768);
      17: set_pair(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845);
      18: set_pair(0, 0, 10, 0, 5, 1, 6, 9);                      // near miss
      19: set_pair(-5, -5, 5, 5, 5, -5, -5, 5);                   // crossing at the center
      20: set_pair(-1, -1, -1, -1, -1, 0, 0, -1);                 // point near a short segment
      default: set_pair(-2, 0, 2, 0, 0, -1, 0, 3);               // plus shape
    endcase
  endtask

  // random pair; the shapes favor touching, collinear and matching cases
  task automatic random_pair();
    int base_x, base_y, dx, dy, n, k1, k2, jit, tmp;
    int shape;
    shape = $urandom_range(99);
    if (shape < 20) begin
      // uniform noise over the full range
      foreach (seg_pt[i]) seg_pt[i] = int'($urandom_range(65535)) - 32768;
    end else if (shape < 35) begin
      // tiny box: many collinear, touching and equal cases
      foreach (seg_pt[i]) seg_pt[i] = pick(-6, 6);
    end else if (shape < 50) begin
      // second segment starts at, or close to, an endpoint of the first
      foreach (seg_pt[i]) seg_pt[i] = pick(-20000, 20000);
      jit = pick(0, 3);
      tmp = $urandom_range(1) * 2;
      seg_pt[4] = seg_pt[tmp] + pick(-jit, jit);
      seg_pt[5] = seg_pt[tmp + 1] + pick(-jit, jit);
    end else if (shape < 60) begin
      // same segment, maybe reversed, maybe slightly moved
      for (int i = 0; i < 4; i++) seg_pt[i] = pick(-30000, 30000);
      jit = ($urandom_range(1) == 0) ? 0 : pick(0, 3);
      tmp = $urandom_range(1) * 2;
      seg_pt[4] = seg_pt[tmp] + pick(-jit, jit);
      seg_pt[5] = seg_pt[tmp + 1] + pick(-jit, jit);
      seg_pt[6] = seg_pt[2 - tmp] + pick(-jit, jit);
      seg_pt[7] = seg_pt[3 - tmp] + pick(-jit, jit);
    end else if (shape < 85) begin
      // points on one line: T junctions and collinear overlaps
      base_x = pick(-15000, 15000);
      base_y = pick(-15000, 15000);
      dx = pick(-300, 300);
      dy = pick(-300, 300);
      n = pick(1, 40);
      seg_pt[0] = base_x;
      seg_pt[1] = base_y;
      seg_pt[2] = base_x + n * dx;
      seg_pt[3] = base_y + n * dy;
      k1 = pick(-n, 2 * n);
      k2 = pick(-n, 2 * n);
      if (shape < 75) k1 = pick(0, n);
      seg_pt[4] = base_x + k1 * dx;
      seg_pt[5] = base_y + k1 * dy;
      if (shape < 75) begin
        seg_pt[6] = seg_pt[4] + pick(-500, 500);
        seg_pt[7] = seg_pt[5] + pick(-500, 500);
      end else begin
        seg_pt[6] = base_x + k2 * dx;
        seg_pt[7] = base_y + k2 * dy;
      end
    end else if (shape < 95) begin
      // two segments through a common center: proper crossings
      base_x = pick(-15000, 15000);
      base_y = pick(-15000, 15000);
      dx = pick(-10000, 10000);
      dy = pick(-10000, 10000);
      seg_pt[0] = base_x - dx;
      seg_pt[1] = base_y - dy;
      seg_pt[2] = base_x + dx;
      seg_pt[3] = base_y + dy;
      dx = pick(-10000, 10000);
      dy = pick(-10000, 10000);
      seg_pt[4] = base_x - dx;
      seg_pt[5] = base_y - dy;
      seg_pt[6] = base_x + dx;
      seg_pt[7] = base_y + dy;
    end else begin
      foreach (seg_pt[i]) seg_pt[i] = edge_value();
    end
    // random order of the segments and of their endpoints
    if ($urandom_range(1) == 1) begin
      for (int i = 0; i < 4; i++) begin
        tmp = seg_pt[i];
        seg_pt[i] = seg_pt[i + 4];
        seg_pt[i + 4] = tmp;
      end
    end
    if ($urandom_range(1) == 1) begin
      for (int i = 0; i < 2; i++) begin
        tmp = seg_pt[i];
        seg_pt[i] = seg_pt[i + 2];
        seg_pt[i + 2] = tmp;
      end
    end
  endtask

  // one tolerance setting: write both bounds while idle, then a batch of random pairs
  task automatic run_phase(tol_t near_v, tol_t line_v, int n_items, bit calm);
    write_tol(CFG_TOLERANCE, near_v);
    write_tol(CFG_DEFAULT_TOL, line_v);
    cfg_we <= 1'b0;
    settings_run++;
    no_idle = calm;
    for (int i = 0; i < n_items; i++) begin
      random_pair();
      send_pair();
    end
    no_idle = 1'b0;
    drain_pipe();
  endtask

  initial begin
    // every input known from time zero
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_TOLERANCE;
    cfg_wdata        = '0;
    in_seg.valid     = 1'b0;
    in_seg.first_ax  = '0;
    in_seg.first_ay  = '0;
    in_seg.first_bx  = '0;
    in_seg.first_by  = '0;
    in_seg.second_ax = '0;
    in_seg.second_ay = '0;
    in_seg.second_bx = '0;
    in_seg.second_by = '0;
    no_idle          = 1'b0;
    sent_pairs       = 0;
    settings_run     = 1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pairs under the reset bounds
    for (int k = 0; k < 22; k++) begin
      directed_pair(k);
      send_pair();
    end
    drain_pipe();

    // zero bounds written explicitly, long stretch with no idling on either side
    run_phase(16'd0, 16'd0, 200, 1'b1);
    // both bounds at their maximum: every coordinate pair matches
    run_phase(16'hffff, 16'hffff, 150, 1'b0);
    // tight coordinate match, loose line test
    run_phase(16'd2, 16'd50, 250, 1'b0);
    // mixed extremes
    run_phase(16'd0, 16'hffff, 150, 1'b0);
    run_phase(16'hffff, 16'd0, 150, 1'b0);
    // random bounds, small for coordinates and anywhere or up to 2000 for the line test
    run_phase(tol_t'($urandom_range(40)), tol_t'($urandom_range(65535)), 150, 1'b0);
    run_phase(tol_t'($urandom_range(8)), tol_t'($urandom_range(2000)), 150, 1'b0);

    $display("run covered %0d segment pairs and %0d checked relations over %0d bound settings",
             sent_pairs, checked, settings_run);
    $display("relations seen: none %0d, intersect %0d, connected %0d, equal %0d",
             rel_tally[REL_NONE], rel_tally[REL_INTERSECT],
             rel_tally[REL_CONNECTED], rel_tally[REL_EQUAL]);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
